/* rtl/sida_pkg.sv */
// shared types and constants for the signed integer to decimal ascii block
// no dependencies; imported by every module of the block except sida_fifo
`default_nettype none

package sida_pkg;

	localparam int VALUE_W    = 32;
	localparam int CHAR_W     = 6;
	localparam int POS_W      = 4;
	localparam int MAX_POS    = 9;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

	// width that holds nine times the largest power of ten below 2^32
	localparam int MULT_W = 34;

	typedef logic [MAX_POS:0][MAX_POS:0][MULT_W-1:0] mult_tbl_t;

	// one classified item: sign, magnitude and place of its leading digit
	typedef struct packed {
		logic               neg;
		logic [VALUE_W-1:0] mag;
		logic [POS_W-1:0]   top_pos;
	} job_t;

	// table of d * 10^k, indexed [k][d]
	function automatic mult_tbl_t build_mult();
		mult_tbl_t t;
		longint    p;
		p = 1;
		for (int k = 0; k <= MAX_POS; k++) begin
			for (int d = 0; d <= MAX_POS; d++) begin
				t[k][d] = MULT_W'(p * d);
			end
			p = p * 10;
		end
		return t;
	endfunction

	localparam mult_tbl_t MULT_TBL = build_mult();

endpackage

`default_nettype wire

/* rtl/sida_fifo.sv */
// short register queue between the front and back parts
// no package dependencies; width and depth come from the instantiating module
`default_nettype none

module sida_fifo #(
	parameter int Width = 8,
	parameter int Depth = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [Width-1:0] wr_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  not_empty,
	output logic      [Width-1:0] rd_data
);

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	logic [Width-1:0] mem_q [Depth];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CW'(Depth));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/sida_front.sv */
// front part: accepts values, forms sign, magnitude and leading digit place
// depends on sida_pkg
`default_nettype none

module sida_front
	import sida_pkg::*;
(
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [VALUE_W-1:0] value,
	input  wire logic               q_full,
	output logic                    q_push,
	output job_t                    job
);

	logic [MAX_POS-1:0] ge;
	logic [VALUE_W-1:0] mag;

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	// two's complement negate; the most negative value maps to 2^31 unsigned
	assign mag = value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;

	// count the powers of ten the magnitude reaches
	always_comb begin
		for (int k = 1; k <= MAX_POS; k++) begin
			ge[k-1] = {2'b00, mag} >= MULT_TBL[k][1];
		end
	end

	assign job.neg     = value[VALUE_W-1];
	assign job.mag     = mag;
	assign job.top_pos = POS_W'($countones(ge));

endmodule

`default_nettype wire

/* rtl/sida_back.sv */
// back part: emits the minus sign and one digit per cycle while the output takes them, leading digit first
// depends on sida_pkg
`default_nettype none

module sida_back
	import sida_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_valid,
	input  wire job_t              q_job,
	output logic                   q_pop,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic      [CHAR_W-1:0] character,
	output logic                   last
);

	logic               busy_q;
	logic               neg_q;
	logic [VALUE_W-1:0] mag_q;
	logic [POS_W-1:0]   pos_q;
	logic               out_valid_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;

	logic               adv;
	logic [MAX_POS-1:0] ge;
	logic [POS_W-1:0]   digit;
	logic [MULT_W-1:0]  rest;

	assign adv   = !out_valid_q || m_tready;
	assign q_pop = !busy_q && q_valid;

	// digit at the current place: how many multiples of 10^pos fit
	always_comb begin
		for (int d = 1; d <= MAX_POS; d++) begin
			ge[d-1] = {2'b00, mag_q} >= MULT_TBL[pos_q][d];
		end
		digit = POS_W'($countones(ge));
		rest  = {2'b00, mag_q} - MULT_TBL[pos_q][digit];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= busy_q;
			end
			if (q_pop) begin
				busy_q <= 1'b1;
			end else if (busy_q && adv && !neg_q && pos_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			neg_q <= q_job.neg;
			mag_q <= q_job.mag;
			pos_q <= q_job.top_pos;
		end else if (busy_q && adv) begin
			if (neg_q) begin
				neg_q  <= 1'b0;
				char_q <= CHAR_MINUS;
				last_q <= 1'b0;
			end else begin
				char_q <= CHAR_ZERO + CHAR_W'(digit);
				last_q <= (pos_q == '0);
				mag_q  <= rest[VALUE_W-1:0];
				pos_q  <= pos_q - POS_W'(1);
			end
		end
	end

	assign m_tvalid  = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

endmodule

`default_nettype wire

/* rtl/signed_int_to_decimal_ascii.sv */
// top level of the signed integer to decimal ascii converter
// depends on sida_pkg, sida_front, sida_fifo and sida_back
//
//  channel  dir  data                         extra
//  s_*      in   tdata[31:0] value (signed)   -
//  m_*      out  tdata[5:0] character         tlast = last character of a number
//
// for an item of digits plus an optional minus, the back part first loads the
// queued item from the queue, then emits its characters one by one, minus first
// the front classifies in the cycle of acceptance and writes the queue, so it
// keeps taking values while the back part works, until the queue is full
// while a character waits to be taken the back part holds; once the last character
// of an item sits in the output register the next queued item can still be loaded
// arst_n clears the queue pointers, the busy flag and the output valid
`default_nettype none

module signed_int_to_decimal_ascii
	import sida_pkg::*;
#(
	parameter int QueueDepth = QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// input items
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] value
	// result items
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic      [7:0] m_tdata,    // [5:0] character, [7:6] zero
	output logic            m_tlast
);

	localparam int JobW = $bits(job_t);

	// front to queue
	logic             q_full;
	logic             q_push;
	job_t             front_job;

	// queue to back
	logic             q_not_empty;
	logic             q_pop;
	logic [JobW-1:0]  q_rd_data;
	job_t             back_job;

	logic [CHAR_W-1:0] character;

	// sign and leading digit place are worked out on the way in
	sida_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.value    (s_tdata[VALUE_W-1:0]),
		.q_full   (q_full),
		.q_push   (q_push),
		.job      (front_job)
	);

	// classified items wait here so both sides stall independently
	sida_fifo #(
		.Width (JobW),
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_data   (front_job),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.rd_data   (q_rd_data)
	);

	assign back_job = job_t'(q_rd_data);

	// digit generation, most significant first
	sida_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_not_empty),
		.q_job     (back_job),
		.q_pop     (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.character (character),
		.last      (m_tlast)
	);

	// character packed in the low bits, padded to a byte
	assign m_tdata = {2'b00, character};

endmodule

`default_nettype wire

/* rtl/sida_checker.sv */
// port-level checks on the converter's output stream, bound to the top level
// depends on sida_pkg
`default_nettype none

module sida_checker
	import sida_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic       m_tlast
);

	logic       take;
	logic [5:0] ch;
	logic       at_start_q;
	logic       after_minus_q;

	assign take = m_tvalid && m_tready;
	assign ch   = m_tdata[5:0];

	// position within the current number's text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q    <= 1'b1;
			after_minus_q <= 1'b0;
		end else if (take) begin
			at_start_q    <= m_tlast;
			after_minus_q <= (ch == CHAR_MINUS);
		end
	end

	// a stalled character holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output character changed while stalled");

	// only minus or a digit ever appears
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:6] == 2'b00 &&
			(ch == CHAR_MINUS || (ch >= CHAR_ZERO && ch <= CHAR_ZERO + 6'd9)))
		else $error("output code is not minus or digit");

	// minus only opens a number and never ends it
	a_minus: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ch == CHAR_MINUS |-> at_start_q && !m_tlast)
		else $error("misplaced minus sign");

	// no leading zero and no negative zero
	a_lead: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ch == CHAR_ZERO && (at_start_q || after_minus_q)
		|-> m_tlast && !after_minus_q)
		else $error("leading zero in output text");

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire
